// ===== rtl/mrv_pkg.sv =====
// ----------------------------------------------------------------------------
// mrv_pkg
// Shared types, constants and helper functions for the manifest record
// validator.
// ----------------------------------------------------------------------------
package mrv_pkg;

  localparam int unsigned RECORD_BYTES = 128;
  localparam int unsigned POS_W        = $clog2(RECORD_BYTES + 1);
  localparam int unsigned CRC_POS      = RECORD_BYTES - 4;

  localparam logic [31:0] CRC_POLY = 32'h82F6_3B78;
  localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

  localparam logic [POS_W-1:0] POS_HDR_END   = POS_W'(8);
  localparam logic [POS_W-1:0] POS_GEN_END   = POS_W'(12);
  localparam logic [POS_W-1:0] POS_WID_END   = POS_W'(14);
  localparam logic [POS_W-1:0] POS_HGT_END   = POS_W'(16);
  localparam logic [POS_W-1:0] POS_PIXB_END  = POS_W'(20);
  localparam logic [POS_W-1:0] POS_PCRC_END  = POS_W'(24);
  localparam logic [POS_W-1:0] POS_TIME_END  = POS_W'(32);
  localparam logic [POS_W-1:0] POS_REV_END   = POS_W'(36);
  localparam logic [POS_W-1:0] POS_PGFMT_END = POS_W'(38);
  localparam logic [POS_W-1:0] POS_VER_BEGIN = POS_W'(40);
  localparam logic [POS_W-1:0] POS_VER_END   = POS_W'(64);
  localparam logic [POS_W-1:0] POS_CRC       = POS_W'(CRC_POS);
  localparam logic [POS_W-1:0] POS_LAST      = POS_W'(RECORD_BYTES - 1);
  localparam logic [POS_W-1:0] POS_FULL      = POS_W'(RECORD_BYTES);

  localparam logic [15:0] EXP_WIDTH_RST   = 16'd240;
  localparam logic [15:0] EXP_HEIGHT_RST  = 16'd320;
  localparam logic [31:0] EXP_PIXB_RST    = 32'd153600;
  localparam logic [7:0]  EXP_FORMAT_RST  = 8'd1;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_EXP_WIDTH  = 3'd0,
    CFG_EXP_HEIGHT = 3'd1,
    CFG_EXP_PIXB   = 3'd2,
    CFG_EXP_FORMAT = 3'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_word_t;

  typedef struct packed {
    logic        record_valid;
    logic [31:0] generation;
    logic [15:0] image_width;
    logic [15:0] image_height;
    logic [31:0] pixel_bytes;
    logic [31:0] pixel_crc;
    logic [63:0] captured_time;
    logic [31:0] ui_revision_number;
    logic [7:0]  ui_page_number;
    logic [7:0]  format_code;
  } out_word_t;

  // Expected header byte at positions 0 to 7: magic, schema, record length.
  function automatic logic [7:0] header_byte(input logic [2:0] pos);
    logic [15:0] rec_len;
    rec_len = 16'(RECORD_BYTES);
    case (pos)
      3'd0:    header_byte = 8'h4C;
      3'd1:    header_byte = 8'h53;
      3'd2:    header_byte = 8'h53;
      3'd3:    header_byte = 8'h43;
      3'd4:    header_byte = 8'h00;
      3'd5:    header_byte = 8'h01;
      3'd6:    header_byte = rec_len[15:8];
      default: header_byte = rec_len[7:0];
    endcase
  endfunction

  // One byte of reflected CRC-32C.
  function automatic logic [31:0] crc32c_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = (c >> 1) ^ (c[0] ? CRC_POLY : 32'd0);
    end
    crc32c_byte = c;
  endfunction

endpackage

// ===== rtl/manifest_record_validator.sv =====
// ----------------------------------------------------------------------------
// manifest_record_validator
// Checks a fixed-size manifest record streamed one byte per word and gives
// one result word with the decoded fields on the marked last byte.
// ----------------------------------------------------------------------------
// The block takes one record byte in every cycle and updates its position
// counter, CRC-32C and field accumulators in the cycle the byte is accepted;
// the byte-wide CRC update sets that rate. The result word for a
// record appears on the output register in the cycle after its last byte is
// accepted. Bytes that are not the last are still taken while a result word
// waits; a last byte is held off only while an earlier result is stalled.
module manifest_record_validator (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  mrv_pkg::in_word_t                   in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output mrv_pkg::out_word_t                  out_data,
  input  logic                                cfg_we,
  input  logic [mrv_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [mrv_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

  logic [15:0] exp_width_r;
  logic [15:0] exp_height_r;
  logic [31:0] exp_pixb_r;
  logic [7:0]  exp_format_r;

  logic [mrv_pkg::POS_W-1:0] pos_r, pos_nxt;
  logic [31:0] crc_r, crc_nxt;
  logic [31:0] stored_crc_r, stored_crc_nxt;
  logic        hdr_ok_r, hdr_ok_nxt;
  logic [31:0] gen_r, gen_nxt;
  logic [15:0] wid_r, wid_nxt;
  logic [15:0] hgt_r, hgt_nxt;
  logic [31:0] pixb_r, pixb_nxt;
  logic [31:0] pcrc_r, pcrc_nxt;
  logic [63:0] time_r, time_nxt;
  logic [31:0] rev_r, rev_nxt;
  logic [15:0] pgfmt_r, pgfmt_nxt;
  logic [1:0]  ver_r, ver_nxt;

  logic               out_valid_r;
  mrv_pkg::out_word_t out_data_r;
  mrv_pkg::out_word_t result;

  logic       in_acc;
  logic       rec_ok;
  logic [7:0] b;
  logic       take;

  assign in_stall  = out_valid_r & out_stall & in_data.last_byte;
  assign in_acc    = in_valid & ~in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign b         = in_data.data_byte;
  assign take      = pos_r < mrv_pkg::POS_FULL;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_width_r  <= mrv_pkg::EXP_WIDTH_RST;
      exp_height_r <= mrv_pkg::EXP_HEIGHT_RST;
      exp_pixb_r   <= mrv_pkg::EXP_PIXB_RST;
      exp_format_r <= mrv_pkg::EXP_FORMAT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        mrv_pkg::CFG_EXP_WIDTH:  exp_width_r  <= cfg_wdata[15:0];
        mrv_pkg::CFG_EXP_HEIGHT: exp_height_r <= cfg_wdata[15:0];
        mrv_pkg::CFG_EXP_PIXB:   exp_pixb_r   <= cfg_wdata[31:0];
        mrv_pkg::CFG_EXP_FORMAT: exp_format_r <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    pos_nxt        = pos_r;
    crc_nxt        = crc_r;
    stored_crc_nxt = stored_crc_r;
    hdr_ok_nxt     = hdr_ok_r;
    gen_nxt        = gen_r;
    wid_nxt        = wid_r;
    hgt_nxt        = hgt_r;
    pixb_nxt       = pixb_r;
    pcrc_nxt       = pcrc_r;
    time_nxt       = time_r;
    rev_nxt        = rev_r;
    pgfmt_nxt      = pgfmt_r;
    ver_nxt        = ver_r;
    if (take) begin
      pos_nxt = pos_r + 1'b1;
      if (pos_r < mrv_pkg::POS_CRC) begin
        crc_nxt = mrv_pkg::crc32c_byte(crc_r, b);
      end else begin
        stored_crc_nxt = {stored_crc_r[23:0], b};
      end
      if (pos_r < mrv_pkg::POS_HDR_END) begin
        if (b != mrv_pkg::header_byte(pos_r[2:0])) begin
          hdr_ok_nxt = 1'b0;
        end
      end else if (pos_r < mrv_pkg::POS_GEN_END) begin
        gen_nxt = {gen_r[23:0], b};
      end else if (pos_r < mrv_pkg::POS_WID_END) begin
        wid_nxt = {wid_r[7:0], b};
      end else if (pos_r < mrv_pkg::POS_HGT_END) begin
        hgt_nxt = {hgt_r[7:0], b};
      end else if (pos_r < mrv_pkg::POS_PIXB_END) begin
        pixb_nxt = {pixb_r[23:0], b};
      end else if (pos_r < mrv_pkg::POS_PCRC_END) begin
        pcrc_nxt = {pcrc_r[23:0], b};
      end else if (pos_r < mrv_pkg::POS_TIME_END) begin
        time_nxt = {time_r[55:0], b};
      end else if (pos_r < mrv_pkg::POS_REV_END) begin
        rev_nxt = {rev_r[23:0], b};
      end else if (pos_r < mrv_pkg::POS_PGFMT_END) begin
        pgfmt_nxt = {pgfmt_r[7:0], b};
      end else if (pos_r >= mrv_pkg::POS_VER_BEGIN && pos_r < mrv_pkg::POS_VER_END) begin
        if (pos_r == mrv_pkg::POS_VER_BEGIN && b != 8'd0) begin
          ver_nxt[0] = 1'b1;
        end
        if (b == 8'd0) begin
          ver_nxt[1] = 1'b1;
        end
      end
    end
  end

  always_comb begin
    rec_ok = (pos_r == mrv_pkg::POS_LAST) && hdr_ok_nxt
           && ((crc_nxt ^ mrv_pkg::CRC_INIT) == stored_crc_nxt)
           && (gen_nxt != 32'd0) && (time_nxt != 64'd0)
           && (wid_nxt == exp_width_r) && (hgt_nxt == exp_height_r)
           && (pixb_nxt == exp_pixb_r) && (pgfmt_nxt[7:0] == exp_format_r)
           && (ver_nxt == 2'b11);
    result = '0;
    if (rec_ok) begin
      result.record_valid       = 1'b1;
      result.generation         = gen_nxt;
      result.image_width        = wid_nxt;
      result.image_height       = hgt_nxt;
      result.pixel_bytes        = pixb_nxt;
      result.pixel_crc          = pcrc_nxt;
      result.captured_time      = time_nxt;
      result.ui_revision_number = rev_nxt;
      result.ui_page_number     = pgfmt_nxt[15:8];
      result.format_code        = pgfmt_nxt[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r        <= '0;
      crc_r        <= mrv_pkg::CRC_INIT;
      stored_crc_r <= '0;
      hdr_ok_r     <= 1'b1;
      gen_r        <= '0;
      wid_r        <= '0;
      hgt_r        <= '0;
      pixb_r       <= '0;
      pcrc_r       <= '0;
      time_r       <= '0;
      rev_r        <= '0;
      pgfmt_r      <= '0;
      ver_r        <= '0;
    end else if (in_acc) begin
      if (in_data.last_byte) begin
        pos_r        <= '0;
        crc_r        <= mrv_pkg::CRC_INIT;
        stored_crc_r <= '0;
        hdr_ok_r     <= 1'b1;
        gen_r        <= '0;
        wid_r        <= '0;
        hgt_r        <= '0;
        pixb_r       <= '0;
        pcrc_r       <= '0;
        time_r       <= '0;
        rev_r        <= '0;
        pgfmt_r      <= '0;
        ver_r        <= '0;
      end else begin
        pos_r        <= pos_nxt;
        crc_r        <= crc_nxt;
        stored_crc_r <= stored_crc_nxt;
        hdr_ok_r     <= hdr_ok_nxt;
        gen_r        <= gen_nxt;
        wid_r        <= wid_nxt;
        hgt_r        <= hgt_nxt;
        pixb_r       <= pixb_nxt;
        pcrc_r       <= pcrc_nxt;
        time_r       <= time_nxt;
        rev_r        <= rev_nxt;
        pgfmt_r      <= pgfmt_nxt;
        ver_r        <= ver_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_acc && in_data.last_byte) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && in_data.last_byte) begin
      out_data_r <= result;
    end
  end

  // The position counter saturates at the record size.
  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= mrv_pkg::POS_FULL)
    else $error("byte position beyond record size");

  // An accepted last byte yields a result word and restarts the record.
  a_last_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_data.last_byte |=> out_valid_r && pos_r == '0 && hdr_ok_r)
    else $error("last byte did not produce a result or clear the record");

  // A byte inside the record advances the position by one.
  a_pos_step: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && !in_data.last_byte && take |=> pos_r == $past(pos_r) + 1'b1)
    else $error("byte position did not advance");

  // An invalid record carries all-zero fields.
  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_data_r.record_valid |-> out_data_r == '0)
    else $error("invalid record result carries nonzero fields");

  // A stalled result word is not replaced.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_stall |=> out_valid_r && $stable(out_data_r))
    else $error("stalled result word changed");

endmodule
